// ===== design/rfc_pkg.sv =====
// Shared types, constants and saturation helpers for the floor texel coordinate unit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rfc_pkg;

  // Default geometry.
  localparam int DEF_SCREEN_ROWS    = 512;
  localparam int DEF_TEXTURE_WIDTH  = 64;
  localparam int DEF_TEXTURE_HEIGHT = 64;

  // Q8.16 format.
  localparam int Q_W    = 24;
  localparam int Q_FRAC = 16;
  localparam int QUOT_W = 24;

  localparam logic [Q_W-1:0] MAG_POS_LIM = 24'h7FFFFF;
  localparam logic [Q_W-1:0] MAG_NEG_LIM = 24'h800000;

  // Texture select threshold: 25.0 in Q8.16.
  localparam logic signed [Q_W-1:0] SEL_LIMIT = 24'sd1638400;

  // One in Q8.16, sized for the blend weight.
  localparam logic signed [Q_W:0] Q_ONE = 25'sd65536;

  localparam int QUEUE_DEPTH = 4;

  // Item as it travels through the two dividers.
  typedef struct packed {
    logic                  err;
    logic                  sel;
    logic                  fvalid;
    logic [8:0]            mrow;
    logic                  neg;
    logic [Q_W-1:0]        wd;
    logic signed [Q_W-1:0] wfx;
    logic signed [Q_W-1:0] wfy;
    logic signed [Q_W-1:0] px;
    logic signed [Q_W-1:0] py;
  } rfc_side_t;

  // Item handed from the front to the back through the queue.
  typedef struct packed {
    logic                  err;
    logic                  sel;
    logic                  fvalid;
    logic [8:0]            mrow;
    logic signed [Q_W-1:0] w;
    logic signed [Q_W-1:0] wfx;
    logic signed [Q_W-1:0] wfy;
    logic signed [Q_W-1:0] px;
    logic signed [Q_W-1:0] py;
  } rfc_job_t;

  // Magnitude of a quotient after saturation to signed Q8.16.
  function automatic logic [Q_W-1:0] sat_mag(input logic [QUOT_W-1:0] q, input logic ovf,
                                              input logic neg);
    logic [Q_W-1:0] r;
    if (neg) begin
      r = (ovf || (q > MAG_NEG_LIM)) ? MAG_NEG_LIM : q;
    end else begin
      r = (ovf || q[QUOT_W-1]) ? MAG_POS_LIM : q;
    end
    return r;
  endfunction

  // Signed quotient after saturation to Q8.16.
  function automatic logic signed [Q_W-1:0] sat_q(input logic [QUOT_W-1:0] q, input logic ovf,
                                                   input logic neg);
    logic [Q_W-1:0] m;
    m = sat_mag(q, ovf, neg);
    return neg ? $signed(~m + 24'd1) : $signed(m);
  endfunction

endpackage

// ===== design/rfc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
// Depends on rfc_pkg for the quotient width.
`timescale 1ns / 1ps

module rfc_div #(
  parameter int NUM_W  = 40,
  parameter int DEN_W  = 24,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [rfc_pkg::QUOT_W-1:0] quot_o,
  output logic              ovf_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int QW = rfc_pkg::QUOT_W;
  localparam int RW = DEN_W + QW;
  localparam int XW = (NUM_W > RW) ? NUM_W : RW;

  logic [RW-1:0]     rem_r  [QW+1];
  logic [QW-1:0]     quot_r [QW+1];
  logic [DEN_W-1:0]  den_r  [QW+1];
  logic              ovf_r  [QW+1];
  logic [SIDE_W-1:0] side_r [QW+1];
  logic              vld_r  [QW+1];

  logic [XW-1:0] num_x;
  logic [XW-1:0] den_top;
  logic          ovf_in;

  // Entry stage: the quotient overflows 24 bits when num >= den * 2^24.
  assign num_x   = XW'(num_i);
  assign den_top = XW'(den_i) << QW;
  assign ovf_in  = (num_x >= den_top);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= ovf_in ? '0 : RW'(num_x);
      quot_r[0] <= '0;
      den_r[0]  <= den_i;
      ovf_r[0]  <= ovf_in;
      side_r[0] <= side_i;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [RW-1:0] shifted;
    logic          take;

    always_comb begin
      shifted = RW'(den_r[k-1]) << (QW - k);
      take    = (rem_r[k-1] >= shifted);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? (rem_r[k-1] - shifted) : rem_r[k-1];
        quot_r[k] <= quot_r[k-1] | (QW'(take) << (QW - k));
        den_r[k]  <= den_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign valid_o = vld_r[QW];
  assign quot_o  = quot_r[QW];
  assign ovf_o   = ovf_r[QW];
  assign side_o  = side_r[QW];

endmodule

// ===== design/rfc_front.sv =====
// Front part: classifies each item, then finds row distance and weight in two dividers.
// Depends on rfc_pkg and rfc_div.
`timescale 1ns / 1ps

module rfc_front #(
  parameter int SCREEN_ROWS = rfc_pkg::DEF_SCREEN_ROWS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [8:0]          in_row,
  input  logic signed [10:0]  in_wall_bottom_row,
  input  logic [23:0]         in_wall_dist,
  input  logic signed [23:0]  in_wall_floor_x,
  input  logic signed [23:0]  in_wall_floor_y,
  input  logic signed [23:0]  in_player_x,
  input  logic signed [23:0]  in_player_y,
  output logic                push,
  output rfc_pkg::rfc_job_t   job
);

  localparam int RB     = ($clog2(SCREEN_ROWS) > 9) ? $clog2(SCREEN_ROWS) : 9;
  localparam int DEN_W  = RB + 2;
  localparam int NUM1_W = $clog2(SCREEN_ROWS + 1) + rfc_pkg::Q_FRAC;
  localparam int NUM2_W = rfc_pkg::Q_W + rfc_pkg::Q_FRAC;
  localparam int SIDE_W = $bits(rfc_pkg::rfc_side_t);
  localparam logic signed [DEN_W-1:0] H_S  = DEN_W'(SCREEN_ROWS);
  localparam logic [DEN_W-1:0]        H_M1 = DEN_W'(SCREEN_ROWS - 1);
  localparam logic [NUM1_W-1:0]       NUM1 = NUM1_W'(SCREEN_ROWS) << rfc_pkg::Q_FRAC;

  logic signed [DEN_W-1:0] den_s;
  logic [DEN_W-1:0]        den_abs;
  logic [DEN_W-1:0]        row_x;
  logic [DEN_W-1:0]        mrow_full;
  logic                    onscreen;
  rfc_pkg::rfc_side_t      side_in;

  // Classification of the incoming item.
  always_comb begin
    row_x     = DEN_W'(in_row);
    den_s     = $signed({row_x[DEN_W-2:0], 1'b0}) - H_S;
    den_abs   = den_s[DEN_W-1] ? DEN_W'(-den_s) : DEN_W'(den_s);
    onscreen  = (row_x < DEN_W'(SCREEN_ROWS));
    mrow_full = H_M1 - row_x;

    side_in.err    = (den_s == '0) || (in_wall_dist == '0);
    side_in.sel    = (in_player_x > rfc_pkg::SEL_LIMIT);
    side_in.fvalid = onscreen && !in_wall_bottom_row[10]
                     && ($signed({2'b00, in_row}) >= in_wall_bottom_row);
    side_in.mrow   = onscreen ? mrow_full[8:0] : 9'd0;
    side_in.neg    = den_s[DEN_W-1];
    side_in.wd     = in_wall_dist;
    side_in.wfx    = in_wall_floor_x;
    side_in.wfy    = in_wall_floor_y;
    side_in.px     = in_player_x;
    side_in.py     = in_player_y;
  end

  // Row distance magnitude: H * 2^16 / |2y - H|.
  logic                          vld1;
  logic [rfc_pkg::QUOT_W-1:0]    quot1;
  logic                          ovf1;
  logic [SIDE_W-1:0]             side1_v;
  rfc_pkg::rfc_side_t            side1;

  rfc_div #(
    .NUM_W  (NUM1_W),
    .DEN_W  (DEN_W),
    .SIDE_W (SIDE_W)
  ) u_div_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid),
    .num_i   (NUM1),
    .den_i   (den_abs),
    .side_i  (side_in),
    .valid_o (vld1),
    .quot_o  (quot1),
    .ovf_o   (ovf1),
    .side_o  (side1_v)
  );

  // Saturate the distance, then divide its magnitude by the wall distance.
  logic [rfc_pkg::Q_W-1:0] mag1;
  logic [NUM2_W-1:0]       num2;

  assign side1 = rfc_pkg::rfc_side_t'(side1_v);
  assign mag1  = rfc_pkg::sat_mag(quot1, ovf1, side1.neg);
  assign num2  = {mag1, {rfc_pkg::Q_FRAC{1'b0}}};

  logic                       vld2;
  logic [rfc_pkg::QUOT_W-1:0] quot2;
  logic                       ovf2;
  logic [SIDE_W-1:0]          side2_v;
  rfc_pkg::rfc_side_t         side2;

  rfc_div #(
    .NUM_W  (NUM2_W),
    .DEN_W  (rfc_pkg::Q_W),
    .SIDE_W (SIDE_W)
  ) u_div_weight (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (vld1),
    .num_i   (num2),
    .den_i   (side1.wd),
    .side_i  (side1_v),
    .valid_o (vld2),
    .quot_o  (quot2),
    .ovf_o   (ovf2),
    .side_o  (side2_v)
  );

  // Saturated weight and the item handed to the queue.
  assign side2 = rfc_pkg::rfc_side_t'(side2_v);

  always_comb begin
    job.err    = side2.err;
    job.sel    = side2.sel;
    job.fvalid = side2.fvalid;
    job.mrow   = side2.mrow;
    job.w      = rfc_pkg::sat_q(quot2, ovf2, side2.neg);
    job.wfx    = side2.wfx;
    job.wfy    = side2.wfy;
    job.px     = side2.px;
    job.py     = side2.py;
  end

  assign push = en && vld2;

endmodule

// ===== design/rfc_queue.sv =====
// Short queue of items between the front and the back parts.
// Depends on rfc_pkg for the item type and depth.
`timescale 1ns / 1ps

module rfc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rfc_pkg::rfc_job_t push_data,
  input  logic              pop,
  output rfc_pkg::rfc_job_t head,
  output logic              empty,
  output logic              full
);

  localparam int DEPTH = rfc_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  rfc_pkg::rfc_job_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? PW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? PW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(DEPTH));

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("queue overfilled");

  property p_no_overflow;
    @(posedge clk) disable iff (!rst_n) full |-> !push || pop;
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("push into full queue");

  property p_no_underflow;
    @(posedge clk) disable iff (!rst_n) empty |-> !pop;
  endproperty
  a_no_underflow: assert property (p_no_underflow) else $error("pop from empty queue");

endmodule

// ===== design/rfc_back.sv =====
// Back part: blends the floor point, takes the texel fraction and holds the result register.
// Depends on rfc_pkg for the item type.
`timescale 1ns / 1ps

module rfc_back #(
  parameter int TEXTURE_WIDTH  = rfc_pkg::DEF_TEXTURE_WIDTH,
  parameter int TEXTURE_HEIGHT = rfc_pkg::DEF_TEXTURE_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rfc_pkg::rfc_job_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        out_texel_x,
  output logic [5:0]        out_texel_y,
  output logic              out_texture_select,
  output logic [8:0]        out_mirror_row,
  output logic              out_mirror_enable,
  output logic              out_floor_valid,
  output logic              out_math_error
);

  logic adv;
  assign adv = !out_valid || !out_stall;
  assign pop = adv && !empty;

  // Stage 1: the four blend products.
  logic                        v1_r;
  logic signed [47:0]          pwx_r, pwy_r;
  logic signed [48:0]          ppx_r, ppy_r;
  logic                        err1_r, sel1_r, fv1_r;
  logic [8:0]                  mrow1_r;
  logic signed [rfc_pkg::Q_W:0] omw;

  assign omw = rfc_pkg::Q_ONE - 25'(head.w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pwx_r   <= head.w * head.wfx;
      pwy_r   <= head.w * head.wfy;
      ppx_r   <= omw * head.px;
      ppy_r   <= omw * head.py;
      err1_r  <= head.err;
      sel1_r  <= head.sel;
      fv1_r   <= head.fvalid;
      mrow1_r <= head.mrow;
    end
  end

  // Stage 2: floor point sums; keep the fraction of its magnitude.
  logic signed [49:0] sum_x, sum_y;
  logic [15:0]        fx_lo, fy_lo;
  logic               v2_r;
  logic [15:0]        frac_x_r, frac_y_r;
  logic               err2_r, sel2_r, fv2_r;
  logic [8:0]         mrow2_r;

  always_comb begin
    sum_x = 50'(pwx_r) + 50'(ppx_r);
    sum_y = 50'(pwy_r) + 50'(ppy_r);
    fx_lo = sum_x[31:16];
    fy_lo = sum_y[31:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frac_x_r <= sum_x[49] ? 16'(-fx_lo) : fx_lo;
      frac_y_r <= sum_y[49] ? 16'(-fy_lo) : fy_lo;
      err2_r   <= err1_r;
      sel2_r   <= sel1_r;
      fv2_r    <= fv1_r;
      mrow2_r  <= mrow1_r;
    end
  end

  // Stage 3: texel index is the fraction scaled by the texture size.
  logic [31:0] tx_p, ty_p;

  assign tx_p = 32'(frac_x_r) * 32'(TEXTURE_WIDTH);
  assign ty_p = 32'(frac_y_r) * 32'(TEXTURE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_texel_x        <= err2_r ? 6'd0 : tx_p[21:16];
      out_texel_y        <= err2_r ? 6'd0 : ty_p[21:16];
      out_texture_select <= sel2_r;
      out_mirror_row     <= mrow2_r;
      out_mirror_enable  <= fv2_r && sel2_r;
      out_floor_valid    <= fv2_r;
      out_math_error     <= err2_r;
    end
  end

  property p_err_zero;
    @(posedge clk) disable iff (!rst_n)
      out_valid && out_math_error |-> (out_texel_x == 6'd0) && (out_texel_y == 6'd0);
  endproperty
  a_err_zero: assert property (p_err_zero) else $error("texel not cleared on math error");

  property p_mirror;
    @(posedge clk) disable iff (!rst_n)
      out_valid && out_mirror_enable |-> out_floor_valid && out_texture_select;
  endproperty
  a_mirror: assert property (p_mirror) else $error("mirror enable without floor and select");

endmodule

// ===== design/raycast_floor_texel_coords_top.sv =====
// Floor-casting texel coordinate unit: one floor pixel per item.
// Use: an item carries a screen row, the column's wall bottom row, wall distance,
// floor point at the wall base and the player position (Q8.16). Each item gives one
// result: texel x and y, texture select, mirrored ceiling row and its enable,
// floor span flag and math error flag.
// Channels: in_ and out_ use valid and stall; a transfer happens on a clock edge
// with valid high and stall low.
// Throughput: one item per cycle while out_stall stays low.
// The path from acceptance to out_valid runs through two 25-stage divider
// pipelines (row distance, then weight), the queue and three back stages
// (blend products, floor sum, texel scaling with the result register).
// When the receiver stalls, the back part and result register hold; the front keeps
// running until the four-entry queue fills, then in_stall rises.
// Reset (rst_n low, synchronous) empties the pipelines and the queue; nothing else
// needs setting up.
// Depends on rfc_pkg, rfc_front, rfc_queue and rfc_back.
`timescale 1ns / 1ps

module raycast_floor_texel_coords_top #(
  parameter int SCREEN_ROWS    = rfc_pkg::DEF_SCREEN_ROWS,
  parameter int TEXTURE_WIDTH  = rfc_pkg::DEF_TEXTURE_WIDTH,
  parameter int TEXTURE_HEIGHT = rfc_pkg::DEF_TEXTURE_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [8:0]         in_row,
  input  logic signed [10:0] in_wall_bottom_row,
  input  logic [23:0]        in_wall_dist,
  input  logic signed [23:0] in_wall_floor_x,
  input  logic signed [23:0] in_wall_floor_y,
  input  logic signed [23:0] in_player_x,
  input  logic signed [23:0] in_player_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_texel_x,
  output logic [5:0]         out_texel_y,
  output logic               out_texture_select,
  output logic [8:0]         out_mirror_row,
  output logic               out_mirror_enable,
  output logic               out_floor_valid,
  output logic               out_math_error
);

  logic              q_full, q_empty, q_push, q_pop;
  rfc_pkg::rfc_job_t q_in, q_head;

  // The front advances whenever the queue has room.
  assign in_stall = q_full;

  rfc_front #(
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .en                 (!q_full),
    .in_valid           (in_valid),
    .in_row             (in_row),
    .in_wall_bottom_row (in_wall_bottom_row),
    .in_wall_dist       (in_wall_dist),
    .in_wall_floor_x    (in_wall_floor_x),
    .in_wall_floor_y    (in_wall_floor_y),
    .in_player_x        (in_player_x),
    .in_player_y        (in_player_y),
    .push               (q_push),
    .job                (q_in)
  );

  rfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  rfc_back #(
    .TEXTURE_WIDTH  (TEXTURE_WIDTH),
    .TEXTURE_HEIGHT (TEXTURE_HEIGHT)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (q_head),
    .empty              (q_empty),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_texel_x        (out_texel_x),
    .out_texel_y        (out_texel_y),
    .out_texture_select (out_texture_select),
    .out_mirror_row     (out_mirror_row),
    .out_mirror_enable  (out_mirror_enable),
    .out_floor_valid    (out_floor_valid),
    .out_math_error     (out_math_error)
  );

endmodule
